// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define DQR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define DQR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/dqr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dqr_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int WIDTH_DEF   = 32;

  localparam int CMD_W       = 3;
  localparam int VAL_W       = 32;
  localparam int CNT_OUT_W   = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (VAL_W + 1 + CNT_OUT_W + CNT_OUT_W + 1 + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_REMOVE_ONE = 3'd3,
    CMD_REMOVE_ALL = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP_RD,
    ST_POP_FIN,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic put_front;
    logic put_back;
    logic set_ovf;
    logic rd_head;
    logic pop_fin;
    logic rd_scan;
    logic scan_step;
    logic remove_all;
    logic scan_fin;
    logic out_load;
  } dqr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_done;
  } dqr_stat_t;

endpackage

`default_nettype wire

// ===== rtl/dqr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dqr_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_fire,
  input  wire logic [dqr_pkg::CMD_W-1:0] in_cmd,
  input  wire dqr_pkg::dqr_stat_t        stat,
  input  wire logic                      out_ready,
  output dqr_pkg::dqr_cmd_t              cmd,
  output logic                           in_ready,
  output logic                           out_valid
);

  dqr_pkg::state_t state, state_next;
  dqr_pkg::cmd_e   op, op_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dqr_pkg::ST_IDLE;
      op        <= dqr_pkg::CMD_PUSH_FRONT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    cmd            = '0;
    in_ready       = 1'b0;
    cmd.remove_all = (op == dqr_pkg::CMD_REMOVE_ALL);

    case (state)
      dqr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          op_next  = dqr_pkg::cmd_e'(in_cmd);
          case (in_cmd)
            dqr_pkg::CMD_PUSH_FRONT,
            dqr_pkg::CMD_PUSH_BACK:  state_next = dqr_pkg::ST_PUSH;
            dqr_pkg::CMD_POP_FRONT:  state_next = dqr_pkg::ST_POP_RD;
            dqr_pkg::CMD_REMOVE_ONE,
            dqr_pkg::CMD_REMOVE_ALL: state_next = dqr_pkg::ST_SCAN_RD;
            default:                 state_next = dqr_pkg::ST_FINISH;
          endcase
        end
      end
      dqr_pkg::ST_PUSH: begin
        if (stat.full) begin
          cmd.set_ovf = 1'b1;
        end else if (op == dqr_pkg::CMD_PUSH_FRONT) begin
          cmd.put_front = 1'b1;
        end else begin
          cmd.put_back = 1'b1;
        end
        state_next = dqr_pkg::ST_FINISH;
      end
      dqr_pkg::ST_POP_RD: begin
        if (stat.empty) begin
          state_next = dqr_pkg::ST_FINISH;
        end else begin
          cmd.rd_head = 1'b1;
          state_next  = dqr_pkg::ST_POP_FIN;
        end
      end
      dqr_pkg::ST_POP_FIN: begin
        cmd.pop_fin = 1'b1;
        state_next  = dqr_pkg::ST_FINISH;
      end
      dqr_pkg::ST_SCAN_RD: begin
        if (stat.scan_done) begin
          cmd.scan_fin = 1'b1;
          state_next   = dqr_pkg::ST_FINISH;
        end else begin
          cmd.rd_scan = 1'b1;
          state_next  = dqr_pkg::ST_SCAN_CMP;
        end
      end
      dqr_pkg::ST_SCAN_CMP: begin
        cmd.scan_step = 1'b1;
        state_next    = dqr_pkg::ST_SCAN_RD;
      end
      dqr_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = dqr_pkg::ST_IDLE;
        end
      end
      default: state_next = dqr_pkg::ST_IDLE;
    endcase

    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dqr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dqr_datapath #(
  parameter int DEPTH = dqr_pkg::DEPTH_DEF,
  parameter int WIDTH = dqr_pkg::WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [dqr_pkg::VAL_W-1:0]       cfg_data,
  input  wire logic [dqr_pkg::VAL_W-1:0]       in_value,
  input  wire dqr_pkg::dqr_cmd_t               cmd,
  output dqr_pkg::dqr_stat_t                   stat,
  output logic [dqr_pkg::OUT_TDATA_W-1:0]      out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]            mem [DEPTH];
  logic [WIDTH-1:0]            rdata;
  logic [AW-1:0]               head;
  logic [CW-1:0]               count;
  logic [WIDTH-1:0]            val;
  logic [CW-1:0]               ri;
  logic [CW-1:0]               wi;
  logic                        found;
  logic [dqr_pkg::VAL_W-1:0]   empty_value;
  logic [dqr_pkg::VAL_W-1:0]   res_value;
  logic                        res_hit;
  logic [CW-1:0]               res_removed;
  logic                        res_ovf;

  logic [63:0]                 in_ext;
  logic [63:0]                 rd_ext;
  logic                        match;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [WIDTH-1:0]            wdata;
  logic                        re;
  logic [AW-1:0]               raddr;
  logic [AW-1:0]               head_dec;
  logic [AW-1:0]               head_inc;

  // logical position to physical slot of the circular store
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] ofs);
    logic [AW:0] s;
    s = (AW+1)'(base) + (AW+1)'(ofs);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign in_ext   = 64'(in_value);
  assign rd_ext   = 64'(rdata);
  assign match    = (rdata == val) && (cmd.remove_all || !found);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;

  assign stat.full      = (count == CW'(DEPTH));
  assign stat.empty     = (count == '0);
  assign stat.scan_done = (ri == count);

  always_comb begin
    we    = 1'b0;
    waddr = phys(head, wi);
    wdata = rdata;
    if (cmd.put_front) begin
      we    = 1'b1;
      waddr = head_dec;
      wdata = val;
    end else if (cmd.put_back) begin
      we    = 1'b1;
      waddr = phys(head, count);
      wdata = val;
    end else if (cmd.scan_step && !match) begin
      we = 1'b1;
    end
    re    = cmd.rd_head || cmd.rd_scan;
    raddr = cmd.rd_scan ? phys(head, ri) : head;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      count       <= '0;
      empty_value <= '0;
    end else begin
      if (cfg_we) begin
        empty_value <= cfg_data;
      end
      if (cmd.put_front) begin
        head  <= head_dec;
        count <= count + 1'b1;
      end else if (cmd.put_back) begin
        count <= count + 1'b1;
      end else if (cmd.pop_fin) begin
        head  <= head_inc;
        count <= count - 1'b1;
      end else if (cmd.scan_fin) begin
        count <= count - res_removed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val         <= in_ext[WIDTH-1:0];
      res_value   <= empty_value;
      res_hit     <= 1'b0;
      res_removed <= '0;
      res_ovf     <= 1'b0;
      ri          <= '0;
      wi          <= '0;
      found       <= 1'b0;
    end
    if (cmd.set_ovf) begin
      res_ovf <= 1'b1;
    end
    if (cmd.pop_fin) begin
      res_value   <= rd_ext[dqr_pkg::VAL_W-1:0];
      res_hit     <= 1'b1;
      res_removed <= CW'(1);
    end
    if (cmd.scan_step) begin
      ri <= ri + 1'b1;
      if (match) begin
        // drop this entry, later ones close the gap
        found       <= 1'b1;
        res_removed <= res_removed + 1'b1;
      end else begin
        wi <= wi + 1'b1;
      end
    end
    if (cmd.scan_fin) begin
      res_hit <= (res_removed != '0);
    end
    if (cmd.out_load) begin
      out_data <= {{dqr_pkg::OUT_PAD_W{1'b0}}, res_ovf, (count == '0),
                   dqr_pkg::CNT_OUT_W'(count), dqr_pkg::CNT_OUT_W'(res_removed),
                   res_hit, res_value};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/deque_with_value_removal_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  tdata fields (low bit first)
// s_*      in         cmd[2:0], item_value[34:3], zero [39:35]
// m_*      out        out_value[31:0], hit[32], removed_count[37:33],
//                     length_now[42:38], is_empty[43], overflow[44], zero [47:45]
// cfg_*    in         empty_value[31:0]
//
// One command at a time; the next is taken once the result sits in the output register.
// Push runs ST_PUSH, pop ST_POP_RD then ST_POP_FIN unless empty; others go to ST_FINISH.
// Removal reads each entry in turn and writes back each one that does not match, closing gaps.
// Reset empties the sequence at once and clears empty_value; no store clearing pass.
// A stalled result holds in the output register; a finished command waits behind it.
module deque_with_value_removal_core #(
  parameter int DEPTH = dqr_pkg::DEPTH_DEF,
  parameter int WIDTH = dqr_pkg::WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [dqr_pkg::IN_TDATA_W-1:0]     s_tdata,   // cmd, item_value
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [dqr_pkg::OUT_TDATA_W-1:0]         m_tdata,   // out_value, hit, removed_count,
                                                             // length_now, is_empty, overflow
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [dqr_pkg::VAL_W-1:0]          cfg_data   // empty_value
);

  dqr_pkg::dqr_cmd_t  cmd;
  dqr_pkg::dqr_stat_t stat;
  logic               in_fire;

  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  dqr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_cmd    (s_tdata[dqr_pkg::CMD_W-1:0]),
    .stat      (stat),
    .out_ready (m_tready),
    .cmd       (cmd),
    .in_ready  (s_tready),
    .out_valid (m_tvalid)
  );

  dqr_datapath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_value (s_tdata[dqr_pkg::CMD_W +: dqr_pkg::VAL_W]),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (m_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/dqr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dqr_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_tvalid,
  input wire logic                               s_tready,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [dqr_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  `DQR_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid, "result valid right after reset")
  `DQR_ASSERT(a_busy_after_take, s_tvalid && s_tready |=> !s_tready, "second command taken at once")
  `DQR_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
  `DQR_ASSERT(a_hit_count, m_tvalid |-> m_tdata[32] == (m_tdata[37:33] != 5'd0), "hit disagrees with removed count")
  `DQR_ASSERT(a_ovf_nohit, m_tvalid && m_tdata[44] |-> !m_tdata[32] && m_tdata[43] == 1'b0, "overflow with hit or empty")

endmodule

bind deque_with_value_removal_core dqr_checker u_dqr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LEN_W       = dqr_pkg::CNT_OUT_W;
  localparam int RESULT_W    = dqr_pkg::VAL_W + 1 + LEN_W + LEN_W + 1 + 1;
  localparam int MAX_REPORTS = 10;

  // Codes with no operation behind them
  localparam logic [dqr_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [dqr_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // Result fields, lowest bits last
  typedef struct packed {
    logic                      overflow;
    logic                      is_empty;
    logic [LEN_W-1:0]          length_now;
    logic [LEN_W-1:0]          removed_count;
    logic                      hit;
    logic [dqr_pkg::VAL_W-1:0] out_value;
  } result_t;

  class deque_tracker;
    logic [dqr_pkg::VAL_W-1:0] contents[$];
    logic [dqr_pkg::VAL_W-1:0] empty_value;
    result_t                   expected_results[$];
    int unsigned               failures;

    function new();
      empty_value = '0;
      failures    = 0;
    endfunction

    function void set_empty_value(logic [dqr_pkg::VAL_W-1:0] value);
      empty_value = value;
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    function void flag(string msg);
      if (failures < MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
      failures++;
    endfunction

    // Apply one accepted command to the shadow deque and queue its result.
    function void note_command(logic [dqr_pkg::CMD_W-1:0] code,
                               logic [dqr_pkg::VAL_W-1:0] value);
      result_t want;
      int      i;
      want = '0;
      want.out_value = empty_value;
      case (code)
        dqr_pkg::CMD_PUSH_FRONT, dqr_pkg::CMD_PUSH_BACK: begin
          if (contents.size() >= dqr_pkg::DEPTH_DEF) want.overflow = 1'b1;
          else if (code == dqr_pkg::CMD_PUSH_FRONT) contents.insert(0, value);
          else contents.push_back(value);
        end
        dqr_pkg::CMD_POP_FRONT: begin
          if (contents.size() > 0) begin
            want.out_value     = contents.pop_front();
            want.hit           = 1'b1;
            want.removed_count = LEN_W'(1);
          end
        end
        dqr_pkg::CMD_REMOVE_ONE: begin
          for (i = 0; i < contents.size(); i++) begin
            if (contents[i] == value) begin
              contents.delete(i);
              want.hit           = 1'b1;
              want.removed_count = LEN_W'(1);
              break;
            end
          end
        end
        dqr_pkg::CMD_REMOVE_ALL: begin
          for (i = contents.size() - 1; i >= 0; i--) begin
            if (contents[i] == value) begin
              contents.delete(i);
              want.removed_count++;
            end
          end
          want.hit = (want.removed_count != 0);
        end
        default: ;
      endcase
      want.length_now = LEN_W'(contents.size());
      want.is_empty   = (contents.size() == 0);
      expected_results.push_back(want);
    endfunction

    function void check_result(logic [dqr_pkg::OUT_TDATA_W-1:0] data);
      result_t got, want;
      got = data[RESULT_W-1:0];
      if (expected_results.size() == 0) begin
        flag($sformatf("result with no command pending: %h", data));
        return;
      end
      want = expected_results.pop_front();
      if (got.out_value !== want.out_value || got.hit !== want.hit ||
          got.removed_count !== want.removed_count || got.length_now !== want.length_now ||
          got.is_empty !== want.is_empty || got.overflow !== want.overflow)
        flag($sformatf({"expected/actual out_value %h/%h hit %b/%b removed %0d/%0d ",
                        "length %0d/%0d empty %b/%b overflow %b/%b"},
                       want.out_value, got.out_value, want.hit, got.hit,
                       want.removed_count, got.removed_count, want.length_now, got.length_now,
                       want.is_empty, got.is_empty, want.overflow, got.overflow));
    endfunction
  endclass

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [dqr_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [dqr_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [dqr_pkg::VAL_W-1:0]       cfg_data  = '0;

  deque_tracker tracker;
  bit           no_gaps     = 1'b0;
  int           cycle_count = 0;

  deque_with_value_removal_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Observe every transaction on the three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.set_empty_value(cfg_data);
      if (s_tvalid && s_tready)
        tracker.note_command(s_tdata[dqr_pkg::CMD_W-1:0],
                             s_tdata[dqr_pkg::CMD_W +: dqr_pkg::VAL_W]);
      if (m_tvalid && m_tready) tracker.check_result(m_tdata);
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls between bursts of ready
  initial begin
    int unsigned stall;
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  task automatic send_command(input logic [dqr_pkg::CMD_W-1:0] code,
                              input logic [dqr_pkg::VAL_W-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(dqr_pkg::IN_TDATA_W - dqr_pkg::CMD_W - dqr_pkg::VAL_W){1'b0}}, value, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending and hold until every result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (tracker.outstanding() != 0);
    @(posedge clk);
  endtask

  task automatic write_empty_value(input logic [dqr_pkg::VAL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                        phase, n, k, pick, push_bias;
    logic [dqr_pkg::CMD_W-1:0] code;
    logic [dqr_pkg::VAL_W-1:0] value;
    logic [dqr_pkg::VAL_W-1:0] value_pool[4];

    tracker = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Pop from empty with the reset default, then with all ones
    send_command(dqr_pkg::CMD_POP_FRONT, '0);
    drain();
    write_empty_value('1);
    send_command(dqr_pkg::CMD_POP_FRONT, '0);
    send_command(dqr_pkg::CMD_REMOVE_ALL, '0);
    send_command(CMD_SPARE_HI, '1);
    send_command(dqr_pkg::CMD_PUSH_FRONT, '0);
    send_command(dqr_pkg::CMD_PUSH_BACK, 32'hA5A5_5A5A);
    send_command(dqr_pkg::CMD_REMOVE_ONE, 32'd1);
    send_command(dqr_pkg::CMD_POP_FRONT, '0);
    send_command(dqr_pkg::CMD_REMOVE_ONE, 32'hA5A5_5A5A);
    // Fill with one value, overflow on both ends, then clear it in one removal
    for (k = 0; k < dqr_pkg::DEPTH_DEF; k++)
      send_command((k % 2 == 0) ? dqr_pkg::CMD_PUSH_FRONT : dqr_pkg::CMD_PUSH_BACK, '1);
    send_command(dqr_pkg::CMD_PUSH_FRONT, 32'h1234_5678);
    send_command(dqr_pkg::CMD_PUSH_BACK, 32'h8765_4321);
    send_command(dqr_pkg::CMD_REMOVE_ALL, '1);
    drain();

    for (phase = 0; phase < 14; phase++) begin
      case (phase % 4)
        0:       write_empty_value('0);
        1:       write_empty_value('1);
        default: write_empty_value($urandom);
      endcase
      no_gaps = (phase % 5 == 2);
      // A small pool of values keeps duplicates and matches frequent
      value_pool[0] = (phase % 2 == 0) ? '0 : '1;
      for (k = 1; k < 4; k++) value_pool[k] = $urandom;
      push_bias = (phase % 3 == 0) ? 62 : (phase % 3 == 1) ? 45 : 22;
      for (n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < push_bias) begin
          code = $urandom_range(0, 1) ? dqr_pkg::CMD_PUSH_BACK : dqr_pkg::CMD_PUSH_FRONT;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 33) code = dqr_pkg::CMD_POP_FRONT;
          else if (pick < 64) code = dqr_pkg::CMD_REMOVE_ONE;
          else if (pick < 95) code = dqr_pkg::CMD_REMOVE_ALL;
          else code = dqr_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end
        value = ($urandom_range(0, 99) < 85) ? value_pool[$urandom_range(0, 3)] : $urandom;
        send_command(code, value);
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (tracker.failures == 0 && tracker.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dqr_pkg.sv
rtl/dqr_ctrl.sv
rtl/dqr_datapath.sv
rtl/deque_with_value_removal_core.sv
rtl/dqr_checker.sv
dv/testbench.sv
